/* hdl/pcre_pkg.sv */
// shared types, codes and constants for the path collision and reach evaluator
package pcre_pkg;

   // request word
   typedef struct packed {
      logic               mode;
      logic [3:0]         entry_index;
      logic               entry_enable;
      logic signed [15:0] rect_x_low;
      logic signed [15:0] rect_y_low;
      logic signed [15:0] rect_x_high;
      logic signed [15:0] rect_y_high;
      logic signed [15:0] heading;
      logic               path_first;
      logic               path_last;
   } req_type;

   // response word
   typedef struct packed {
      logic [1:0]  outcome;
      logic [11:0] reach_time;
      logic [13:0] score;
   } rsp_type;

   // one obstacle rectangle
   typedef struct packed {
      logic signed [15:0] xl;
      logic signed [15:0] yl;
      logic signed [15:0] xh;
      logic signed [15:0] yh;
   } rect_type;

   // scan handshake between top and obstacle unit
   typedef struct packed {
      logic done;
      logic hit;
   } scan_stat_type;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   localparam logic [1:0] OUT_REACHED   = 2'd0;
   localparam logic [1:0] OUT_COLLISION = 2'd1;
   localparam logic [1:0] OUT_MISSED    = 2'd2;

   localparam logic [1:0] DEC_NONE    = 2'd0;
   localparam logic [1:0] DEC_REACHED = 2'd1;
   localparam logic [1:0] DEC_FAILED  = 2'd2;

   localparam logic [13:0] PENALTY = 14'd10000;

   // register indexes
   localparam logic [3:0] REG_START_X   = 4'd0;
   localparam logic [3:0] REG_START_Y   = 4'd1;
   localparam logic [3:0] REG_GOAL_X    = 4'd2;
   localparam logic [3:0] REG_GOAL_Y    = 4'd3;
   localparam logic [3:0] REG_AREA_W    = 4'd4;
   localparam logic [3:0] REG_AREA_H    = 4'd5;
   localparam logic [3:0] REG_STEP      = 4'd6;
   localparam logic [3:0] REG_MARGIN    = 4'd7;

   // cordic constants: gain in Q30, arctangent table in angle units of 2^32 per turn
   localparam int CORDIC_ITERS = 30;
   localparam int CW = 34;
   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

   function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
      logic signed [CW-1:0] r;
      case (i)
         5'd0:  r = 34'sd536870912;
         5'd1:  r = 34'sd316933406;
         5'd2:  r = 34'sd167458907;
         5'd3:  r = 34'sd85004756;
         5'd4:  r = 34'sd42667331;
         5'd5:  r = 34'sd21354465;
         5'd6:  r = 34'sd10679838;
         5'd7:  r = 34'sd5340245;
         5'd8:  r = 34'sd2670163;
         5'd9:  r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         5'd24: r = 34'sd41;
         5'd25: r = 34'sd20;
         5'd26: r = 34'sd10;
         5'd27: r = 34'sd5;
         5'd28: r = 34'sd3;
         5'd29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hdl/path_collision_reach_eval.sv */
// top level: registers, path state and step sequencer of the path evaluator
//
// channel   direction  handshake             word
// req       in         req_valid/req_stall   pcre_pkg::req_type
// rsp       out        rsp_valid/rsp_stall   pcre_pkg::rsp_type
// csr       in         csr_valid/csr_ready   csr_index, csr_data
//
// a load word leaves the block idle. a heading word holds req_stall high after it
// is taken, through 30 rotations of the cordic unit, a rounding step, then the
// multiply and the add. the obstacle scan and the goal check run beside it,
// hidden for up to 26 obstacles. past the step limit a heading word goes from the
// check state back to idle, or to the result. reset is synchronous and clears the
// valid bits of the store at once. while a result is stalled the block holds it
// and takes no new word.
module path_collision_reach_eval #(
   parameter int NUM_OBSTACLES = 16,
   parameter int MAX_STEPS = 128,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pcre_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcre_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import pcre_pkg::*;

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int SCW = $clog2(MAX_STEPS + 1);
   localparam int PW = TW + 13;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SCAN, S_GOAL, S_CMP, S_WAIT, S_MUL, S_ADD, S_OUT
   } state_type;

   state_type state_ff;
   logic signed [15:0] start_x_ff, start_y_ff, goal_x_ff, goal_y_ff;
   logic [14:0] area_w_ff, area_h_ff;
   logic [11:0] step_ff, margin_ff;
   logic signed [15:0] pos_x_ff, pos_y_ff;
   logic [SCW-1:0] count_ff;
   logic [1:0] dec_ff;
   logic [11:0] dec_time_ff;
   logic last_ff;
   logic [33:0] gx2_ff, gy2_ff;
   logic signed [13:0] dx_ff, dy_ff;

   logic req_acc, cordic_done, scan_start, area_fail;
   logic signed [TW-1:0] cos_v, sin_v;
   scan_stat_type scan_stat;
   logic signed [16:0] gx, gy, sx, sy;
   logic signed [PW-1:0] px_prod, py_prod;
   logic [34:0] dist2;

   assign req_acc = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = state_ff == S_OUT;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         area_w_ff <= 15'd1280;
         area_h_ff <= 15'd2048;
         step_ff <= 12'd64;
         margin_ff <= 12'd26;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START_X: start_x_ff <= csr_data;
            REG_START_Y: start_y_ff <= csr_data;
            REG_GOAL_X:  goal_x_ff <= csr_data;
            REG_GOAL_Y:  goal_y_ff <= csr_data;
            REG_AREA_W:  area_w_ff <= csr_data[14:0];
            REG_AREA_H:  area_h_ff <= csr_data[14:0];
            REG_STEP:    step_ff <= csr_data[11:0];
            REG_MARGIN:  margin_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   pcre_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic (
      .clock(clock),
      .reset(reset),
      .start(req_acc && req_data.mode == MODE_STEP),
      .heading(req_data.heading),
      .done(cordic_done),
      .cos_out(cos_v),
      .sin_out(sin_v)
   );

   pcre_obst #(.NUM_OBSTACLES(NUM_OBSTACLES)) u_obst (
      .clock(clock),
      .reset(reset),
      .wr_en(req_acc && req_data.mode == MODE_LOAD),
      .wr_index(req_data.entry_index),
      .wr_enable(req_data.entry_enable),
      .wr_rect({req_data.rect_x_low, req_data.rect_y_low,
                req_data.rect_x_high, req_data.rect_y_high}),
      .start(scan_start),
      .px(pos_x_ff),
      .py(pos_y_ff),
      .margin(margin_ff),
      .stat(scan_stat)
   );

   // area bounds, goal distance and move arithmetic
   assign area_fail = pos_x_ff < 0 || pos_y_ff < 0 ||
                      {pos_x_ff[15], pos_x_ff} > $signed({2'b00, area_w_ff}) ||
                      {pos_y_ff[15], pos_y_ff} > $signed({2'b00, area_h_ff});
   assign scan_start = state_ff == S_CHECK && count_ff < SCW'(MAX_STEPS) &&
                       dec_ff == DEC_NONE && !area_fail;
   assign gx = {pos_x_ff[15], pos_x_ff} - {goal_x_ff[15], goal_x_ff};
   assign gy = {pos_y_ff[15], pos_y_ff} - {goal_y_ff[15], goal_y_ff};
   assign dist2 = {1'b0, gx2_ff} + {1'b0, gy2_ff};
   assign px_prod = PW'($signed({1'b0, step_ff})) * PW'(cos_v)
                    + (PW'(1) <<< (TRIG_FRAC_BITS - 1));
   assign py_prod = PW'($signed({1'b0, step_ff})) * PW'(sin_v)
                    + (PW'(1) <<< (TRIG_FRAC_BITS - 1));
   assign sx = {pos_x_ff[15], pos_x_ff} + 17'(dx_ff);
   assign sy = {pos_y_ff[15], pos_y_ff} + 17'(dy_ff);

   // step sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         count_ff <= '0;
         dec_ff <= DEC_NONE;
         dec_time_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_acc && req_data.mode == MODE_STEP) begin
                  last_ff <= req_data.path_last;
                  if (req_data.path_first) begin
                     pos_x_ff <= start_x_ff;
                     pos_y_ff <= start_y_ff;
                     count_ff <= '0;
                     dec_ff <= DEC_NONE;
                     dec_time_ff <= '0;
                  end
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (count_ff >= SCW'(MAX_STEPS)) begin
                  state_ff <= last_ff ? S_OUT : S_IDLE;
               end else if (dec_ff != DEC_NONE) begin
                  state_ff <= S_WAIT;
               end else if (area_fail) begin
                  dec_ff <= DEC_FAILED;
                  state_ff <= S_WAIT;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan_stat.done) begin
                  if (scan_stat.hit) begin
                     dec_ff <= DEC_FAILED;
                     state_ff <= S_WAIT;
                  end else begin
                     state_ff <= S_GOAL;
                  end
               end
            end
            S_GOAL: begin
               gx2_ff <= 34'(gx * gx);
               gy2_ff <= 34'(gy * gy);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (dist2 < 35'(step_ff * step_ff)) begin
                  dec_ff <= DEC_REACHED;
                  dec_time_ff <= 12'(count_ff);
               end
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (cordic_done) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               dx_ff <= 14'(px_prod >>> TRIG_FRAC_BITS);
               dy_ff <= 14'(py_prod >>> TRIG_FRAC_BITS);
               state_ff <= S_ADD;
            end
            S_ADD: begin
               pos_x_ff <= (sx > 17'sd32767) ? 16'sh7fff :
                           (sx < -17'sd32768) ? 16'sh8000 : sx[15:0];
               pos_y_ff <= (sy > 17'sd32767) ? 16'sh7fff :
                           (sy < -17'sd32768) ? 16'sh8000 : sy[15:0];
               count_ff <= count_ff + 1'b1;
               state_ff <= last_ff ? S_OUT : S_IDLE;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result word
   always_comb begin
      if (dec_ff == DEC_REACHED) begin
         rsp_data.outcome = OUT_REACHED;
         rsp_data.reach_time = dec_time_ff;
         rsp_data.score = {2'b00, dec_time_ff};
      end else begin
         rsp_data.outcome = (dec_ff == DEC_FAILED) ? OUT_COLLISION : OUT_MISSED;
         rsp_data.reach_time = '0;
         rsp_data.score = PENALTY;
      end
   end
endmodule

/* hdl/pcre_cordic.sv */
// iterative cordic giving rounded cos and sin of a heading, one rotation per cycle
module pcre_cordic #(
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [15:0]             heading,
   output logic                           done,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_out,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_out
);
   import pcre_pkg::*;

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int SH = 30 - TRIG_FRAC_BITS;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0]           i_ff, i_in;
   logic                 run_ff, run_in, done_ff, done_in, flip_ff, flip_in;
   logic signed [TW-1:0] c_ff, c_in, s_ff, s_in;
   logic [31:0]          ang;
   logic signed [CW-1:0] xs, ys, xr, yr;

   // rounding of the final vector
   assign xr = (x_ff + (CW'(1) <<< (SH - 1))) >>> SH;
   assign yr = (y_ff + (CW'(1) <<< (SH - 1))) >>> SH;
   assign xs = x_ff >>> i_ff;
   assign ys = y_ff >>> i_ff;
   assign ang = {heading, 16'h0000};

   // start load, rotation step and final rounded output
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      run_in = run_ff;
      done_in = done_ff;
      flip_in = flip_ff;
      c_in = c_ff;
      s_in = s_ff;
      if (start) begin
         flip_in = ang[31] ^ ang[30];
         z_in = CW'($signed({ang[31] ^ (ang[31] ^ ang[30]), ang[30:0]}));
         x_in = GAIN_Q30;
         y_in = '0;
         i_in = '0;
         run_in = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         if (!z_ff[CW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_q30(i_ff);
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_q30(i_ff);
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(CORDIC_ITERS - 1)) begin
            run_in = 1'b0;
         end
      end else if (!done_ff && i_ff == 5'(CORDIC_ITERS)) begin
         c_in = flip_ff ? -TW'(xr) : TW'(xr);
         s_in = flip_ff ? -TW'(yr) : TW'(yr);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         i_ff <= i_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
      c_ff <= c_in;
      s_ff <= s_in;
   end

   assign done = done_ff;
   assign cos_out = c_ff;
   assign sin_out = s_ff;
endmodule

/* hdl/pcre_obst.sv */
// obstacle store and sequential scan, one rectangle compared per cycle
module pcre_obst #(
   parameter int NUM_OBSTACLES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [3:0]              wr_index,
   input  logic                    wr_enable,
   input  pcre_pkg::rect_type      wr_rect,
   input  logic                    start,
   input  logic signed [15:0]      px,
   input  logic signed [15:0]      py,
   input  logic [11:0]             margin,
   output pcre_pkg::scan_stat_type stat
);
   import pcre_pkg::*;

   localparam int AW = (NUM_OBSTACLES > 1) ? $clog2(NUM_OBSTACLES) : 1;

   rect_type          mem [NUM_OBSTACLES];
   logic              valid_ff [NUM_OBSTACLES];
   logic [AW:0]       cnt_ff;
   logic              run_ff, pipe_ff, last_ff, chk_ff, hit_ff, fin_ff;
   rect_type          rd_ff;
   logic              wr_ok;
   logic signed [16:0] m17, xlo, xhi, ylo, yhi, px17, py17;
   logic              inside_rect;

   assign wr_ok = 32'(wr_index) < NUM_OBSTACLES;

   // write port and valid bits
   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[AW'(wr_index)] <= wr_rect;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_OBSTACLES; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (wr_en && wr_ok && AW'(wr_index) == AW'(k)) begin
            valid_ff[k] <= wr_enable;
         end
      end
   end

   // widened rectangle compare
   assign m17 = {5'b0, margin};
   assign px17 = {px[15], px};
   assign py17 = {py[15], py};
   assign xlo = {rd_ff.xl[15], rd_ff.xl} - m17;
   assign xhi = {rd_ff.xh[15], rd_ff.xh} + m17;
   assign ylo = {rd_ff.yl[15], rd_ff.yl} - m17;
   assign yhi = {rd_ff.yh[15], rd_ff.yh} + m17;
   assign inside_rect = px17 >= xlo && px17 <= xhi && py17 >= ylo && py17 <= yhi;

   // read stage then compare stage
   always_ff @(posedge clock) begin
      rd_ff <= mem[cnt_ff[AW-1:0]];
      chk_ff <= valid_ff[cnt_ff[AW-1:0]];
      if (reset) begin
         run_ff <= 1'b0;
         pipe_ff <= 1'b0;
         last_ff <= 1'b0;
         fin_ff <= 1'b0;
         hit_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         fin_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            hit_ff <= 1'b0;
            pipe_ff <= 1'b0;
         end else begin
            pipe_ff <= run_ff;
            last_ff <= cnt_ff == (AW+1)'(NUM_OBSTACLES - 1);
            if (run_ff) begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == (AW+1)'(NUM_OBSTACLES - 1)) begin
                  run_ff <= 1'b0;
               end
            end
            if (pipe_ff) begin
               if (chk_ff && inside_rect) begin
                  hit_ff <= 1'b1;
               end
               if (last_ff) begin
                  fin_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign stat.done = fin_ff;
   assign stat.hit = hit_ff;
endmodule

/* hdl/pcre_checker.sv */
// port level checks on the path evaluator, bound to the top level
module pcre_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pcre_pkg::rsp_type rsp_data
);
   import pcre_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");

   // no new request taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   // score follows outcome
   a_score_reached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome == OUT_REACHED |->
         rsp_data.score == {2'b00, rsp_data.reach_time})
      else $error("score differs from reach time");

   a_score_penalty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome != OUT_REACHED |->
         rsp_data.score == PENALTY && rsp_data.reach_time == 12'd0 &&
         (rsp_data.outcome == OUT_COLLISION || rsp_data.outcome == OUT_MISSED))
      else $error("bad penalty result");

   // after an accepted request, a result word shows only with req_stall high
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid || req_stall)
      else $error("busy flag lost");
endmodule

bind path_collision_reach_eval pcre_checker u_pcre_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

/* test/tb_path_collision_reach_eval.sv */
// testbench for the path collision and reach evaluator: scoreboard class and stimulus
`timescale 1ns / 1ps

module tb_path_collision_reach_eval;
   import pcre_pkg::*;

   localparam int NOBS = 16;
   localparam int MAXST = 128;
   localparam int FRAC = 15;

   // scoreboard: predicts path outcomes and checks response words
   class path_score_board;
      logic [15:0] regs [8];
      logic signed [15:0] xl [NOBS], yl [NOBS], xh [NOBS], yh [NOBS];
      bit          live [NOBS];
      int          pos_x, pos_y, steps, verdict, verdict_time;
      rsp_type     pending [$];
      int          errors, checked;

      function new();
         regs[0] = 0; regs[1] = 0; regs[2] = 0; regs[3] = 0;
         regs[4] = 1280; regs[5] = 2048; regs[6] = 64; regs[7] = 26;
         foreach (live[k]) live[k] = 0;
         pos_x = 0; pos_y = 0; steps = 0; verdict = 0; verdict_time = 0;
         errors = 0; checked = 0;
      endfunction

      function void write_reg(int idx, logic [15:0] v);
         logic [15:0] mask;
         mask = (idx < 4) ? 16'hffff : (idx < 6) ? 16'h7fff : 16'h0fff;
         regs[idx] = v & mask;
      endfunction

      function longint fshift(longint v, int s);
         return v >>> s;
      endfunction

      // cordic rotation giving cos and sin with FRAC fraction bits
      function void rotate(logic [15:0] hd, output longint c, output longint s);
         logic [31:0] a;
         bit flip;
         longint x, y, z, xs, ys;
         int sh;
         a = {hd, 16'h0};
         flip = 0;
         x = 652032874; y = 0;
         sh = 30 - FRAC;
         if (a >= 32'h4000_0000 && a < 32'hc000_0000) begin
            a = a + 32'h8000_0000;
            flip = 1;
         end
         z = longint'($signed(a));
         for (int i = 0; i < 30; i++) begin
            xs = fshift(x, i); ys = fshift(y, i);
            if (z >= 0) begin
               x -= ys; y += xs; z -= longint'(atan_q30(i[4:0]));
            end else begin
               x += ys; y -= xs; z += longint'(atan_q30(i[4:0]));
            end
         end
         c = fshift(x + (longint'(1) <<< (sh - 1)), sh);
         s = fshift(y + (longint'(1) <<< (sh - 1)), sh);
         if (flip) begin
            c = -c; s = -s;
         end
      endfunction

      function bit blocked(int px, int py);
         int m;
         m = regs[7];
         if (px < 0 || px > int'(regs[4]) || py < 0 || py > int'(regs[5])) return 1;
         for (int k = 0; k < NOBS; k++)
            if (live[k] && px >= xl[k] - m && px <= xh[k] + m &&
                py >= yl[k] - m && py <= yh[k] + m) return 1;
         return 0;
      endfunction

      function int clip16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return int'(v);
      endfunction

      // note one accepted request word
      function void note_request(req_type w);
         longint st, c, s, gx, gy;
         rsp_type r;
         if (w.mode == MODE_LOAD) begin
            xl[w.entry_index] = w.rect_x_low; yl[w.entry_index] = w.rect_y_low;
            xh[w.entry_index] = w.rect_x_high; yh[w.entry_index] = w.rect_y_high;
            live[w.entry_index] = w.entry_enable;
            return;
         end
         if (w.path_first) begin
            pos_x = $signed(regs[0]); pos_y = $signed(regs[1]);
            steps = 0; verdict = DEC_NONE; verdict_time = 0;
         end
         if (steps < MAXST) begin
            st = regs[6];
            if (verdict == DEC_NONE) begin
               if (blocked(pos_x, pos_y)) verdict = DEC_FAILED;
               else begin
                  gx = pos_x - longint'($signed(regs[2]));
                  gy = pos_y - longint'($signed(regs[3]));
                  if (gx * gx + gy * gy < st * st) begin
                     verdict = DEC_REACHED;
                     verdict_time = steps & 12'hfff;
                  end
               end
            end
            rotate(w.heading, c, s);
            pos_x = clip16(pos_x + fshift(st * c + (1 << (FRAC - 1)), FRAC));
            pos_y = clip16(pos_y + fshift(st * s + (1 << (FRAC - 1)), FRAC));
            steps++;
         end
         if (!w.path_last) return;
         if (verdict == DEC_REACHED) begin
            r.outcome = OUT_REACHED;
            r.reach_time = verdict_time[11:0];
            r.score = 14'(verdict_time);
         end else begin
            r.outcome = (verdict == DEC_FAILED) ? OUT_COLLISION : OUT_MISSED;
            r.reach_time = '0;
            r.score = PENALTY;
         end
         pending = {pending, r};
      endfunction

      // compare one response word with the oldest prediction
      function void check_response(rsp_type got);
         rsp_type exp_w;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %p", got);
            return;
         end
         exp_w = pending.pop_front();
         if (got.outcome !== exp_w.outcome || got.reach_time !== exp_w.reach_time ||
             got.score !== exp_w.score) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %p, got %p", exp_w, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   req_type req_data = '0;
   logic rsp_valid, rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_valid = 0, csr_ready;
   logic [3:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   path_score_board board = new();
   int words_sent = 0, paths_run = 0;

   path_collision_reach_eval u_top (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #5 clock = ~clock;

   // response side: random stalls, check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_stall <= 1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // run limit
   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

   // send one request word after a random gap; valid stays high only when
   // the next word follows at once
   task automatic send_word(req_type w, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
      csr_valid <= 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      board.note_request(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(logic [3:0] idx, logic [15:0] v);
      csr_valid <= 1; csr_index <= idx; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, v);
      @(negedge clock);
   endtask

   // wait for all predicted words, then let a heading word finish
   task automatic drain();
      int n;
      n = 0;
      req_valid <= 0;
      csr_valid <= 0;
      while (board.pending.size() != 0 && n < 200000) begin
         @(negedge clock); n++;
      end
      repeat (60) @(negedge clock);
   endtask

   function automatic req_type load_word(int idx, bit en, int x0, int y0, int x1, int y1);
      req_type w;
      w = '0;
      w.mode = MODE_LOAD; w.entry_index = idx[3:0]; w.entry_enable = en;
      w.rect_x_low = x0[15:0]; w.rect_y_low = y0[15:0];
      w.rect_x_high = x1[15:0]; w.rect_y_high = y1[15:0];
      w.path_last = 1'($urandom_range(0, 1));
      return w;
   endfunction

   function automatic req_type step_word(logic [15:0] hd, bit first, bit last);
      req_type w;
      w = '0;
      w.mode = MODE_STEP; w.heading = hd; w.path_first = first; w.path_last = last;
      w.rect_x_low = 16'($urandom); w.entry_index = 4'($urandom);
      return w;
   endfunction

   // one path of random length; headings bias toward a random base direction
   task automatic run_path(int len);
      logic [15:0] base;
      base = 16'($urandom);
      for (int i = 0; i < len; i++)
         send_word(step_word(($urandom_range(0, 4) == 0) ? 16'($urandom) :
                             16'(base + $urandom_range(0, 4096) - 2048),
                             i == 0, i == len - 1));
      paths_run++;
   endtask

   task automatic random_obstacles();
      int x, y;
      for (int k = 0; k < $urandom_range(1, 6); k++) begin
         x = $urandom_range(0, 1280); y = $urandom_range(0, 2048);
         send_word(load_word($urandom_range(0, 15), $urandom_range(0, 3) != 0,
                             x, y, x + $urandom_range(0, 300) - 30,
                             y + $urandom_range(0, 300) - 30));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, disable, inverted rectangle, headings on axes
      send_word(load_word(0, 1, 300, 300, 400, 400));
      send_word(load_word(1, 1, 32767, 32767, -32768, -32768));
      send_word(load_word(2, 0, -32768, -32768, 32767, 32767));
      send_word(load_word(15, 1, 1000, -32768, 1100, -20000));
      send_word(step_word(16'h0000, 1, 0));
      send_word(step_word(16'h4000, 0, 0));
      send_word(step_word(16'h8000, 0, 0));
      send_word(step_word(16'hc000, 0, 0));
      send_word(step_word(16'h7fff, 0, 1));
      send_word(step_word(16'h2000, 0, 1));
      send_word(step_word(16'hffff, 1, 1));
      send_word(step_word(16'h0001, 1, 0), 1);
      send_word(step_word(16'h6000, 0, 1), 1);
      drain();
      // goal near the start: reached at time zero
      write_csr(REG_START_X, 16'd100); write_csr(REG_START_Y, 16'd100);
      write_csr(REG_GOAL_X, 16'd120); write_csr(REG_GOAL_Y, 16'd100);
      send_word(step_word(16'h0000, 1, 1));
      drain();
      // start outside the area
      write_csr(REG_START_X, 16'h8000);
      send_word(step_word(16'h0000, 1, 1));
      drain();
      // long path past the step limit, with saturation of the position
      write_csr(REG_START_X, 16'h7f00); write_csr(REG_STEP, 16'hfff);
      write_csr(REG_AREA_W, 16'h7fff); write_csr(REG_AREA_H, 16'h7fff);
      write_csr(REG_MARGIN, 16'hfff);
      send_word(load_word(2, 0, 0, 0, 0, 0));
      for (int i = 0; i < 135; i++) send_word(step_word(16'h0000, i == 0, i == 134), 1);
      drain();

      // random phases with varying settings
      for (int ph = 0; ph < 10; ph++) begin
         write_csr(REG_AREA_W, (ph == 1) ? 16'd0 : 16'($urandom_range(600, 4000)));
         write_csr(REG_AREA_H, (ph == 1) ? 16'd0 : 16'($urandom_range(600, 4000)));
         write_csr(REG_STEP, (ph == 2) ? 16'd0 : (ph == 3) ? 16'hfff :
                   16'($urandom_range(16, 200)));
         write_csr(REG_MARGIN, (ph == 4) ? 16'd0 : (ph == 5) ? 16'hfff :
                   16'($urandom_range(0, 60)));
         write_csr(REG_START_X, (ph == 6) ? 16'h8000 : 16'($urandom_range(0, 1000)));
         write_csr(REG_START_Y, (ph == 6) ? 16'h7fff : 16'($urandom_range(0, 1000)));
         write_csr(REG_GOAL_X, (ph == 7) ? 16'h7fff : 16'($urandom_range(0, 1500)));
         write_csr(REG_GOAL_Y, (ph == 7) ? 16'h8000 : 16'($urandom_range(0, 1500)));
         random_obstacles();
         while (words_sent < 250 + ph * 100) begin
            if ($urandom_range(0, 9) == 0) random_obstacles();
            else if ($urandom_range(0, 9) == 0)
               send_word(step_word(16'($urandom), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))));
            else run_path($urandom_range(1, 12));
         end
         drain();
      end

      $display("sent %0d request words over %0d random paths, checked %0d responses",
               words_sent, paths_run, board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
